[sv/eatst_pkg.sv]
// ---------------------------------------------------------------------------
// eatst_pkg: shared types and constants for the encoder angle/turns tracker
// Holds the item structs, the action codes, register indexes and defaults.
// ---------------------------------------------------------------------------
`default_nettype none

package eatst_pkg;

  // Default angle resolution in bits; one turn is 2**ANGLE_BITS counts.
  localparam int ANGLE_BITS_DEF = 12;

  localparam int RAW_W   = 16;
  localparam int MECH_W  = 12;
  localparam int ELEC_W  = 18;
  localparam int TURNS_W = 32;
  localparam int SPEED_W = 32;
  localparam int PP_W    = 7;
  localparam int GAIN_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PP_W-1:0]   PP_RESET   = 7'd7;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

  localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 1'd1;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_ZERO   = 2'd2,
    ACT_IDLE   = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [RAW_W-1:0]   raw_word;
  } in_item_t;

  typedef struct packed {
    logic [MECH_W-1:0]         mech_angle;
    logic [ELEC_W-1:0]         elec_angle;
    logic signed [TURNS_W-1:0] turn_count;
    logic signed [SPEED_W-1:0] speed;
  } out_item_t;

  // Load strobes for the two registered stages of the scaling unit.
  typedef struct packed {
    logic ld_mul;
    logic ld_out;
  } pipe_ctl_t;

endpackage

`default_nettype wire

[sv/eatst_core.sv]
// ---------------------------------------------------------------------------
// eatst_core: angle extraction, turn unwrap and tick bookkeeping
// Owns the tracker state and registers the per-item angle, turns and delta.
// ---------------------------------------------------------------------------
`default_nettype none

module eatst_core #(
  parameter int ANGLE_BITS = eatst_pkg::ANGLE_BITS_DEF,
  parameter int DW         = ANGLE_BITS + 33
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire eatst_pkg::action_t             action,
  input  wire logic [eatst_pkg::RAW_W-1:0]    raw_word,
  output logic [ANGLE_BITS-1:0]               angle_o,
  output logic [eatst_pkg::TURNS_W-1:0]       turns_o,
  output logic signed [DW-1:0]                delta_o
);
  import eatst_pkg::*;

  localparam int AB = ANGLE_BITS;

  logic [RAW_W-1:0]   held_r, held_nxt;
  logic [AB-1:0]      offset_r, offset_nxt;
  logic [AB-1:0]      prev_r, prev_nxt;
  logic [TURNS_W-1:0] turns_r, turns_nxt;
  logic [AB-1:0]      tprev_angle_r, tprev_angle_nxt;
  logic [TURNS_W-1:0] tprev_turns_r, tprev_turns_nxt;

  logic [AB-1:0]      angle_r, angle_nxt;
  logic [TURNS_W-1:0] tout_r, tout_nxt;
  logic signed [DW-1:0] delta_r, delta_nxt;

  logic [RAW_W-1:0]   word;
  logic [AB-1:0]      raw_angle;
  logic [AB-1:0]      mech;
  logic signed [AB:0] d;
  logic [AB:0]        d_neg;
  logic [AB-1:0]      mag;
  logic [AB+2:0]      mag5;
  logic               wrap;
  logic [TURNS_W-1:0] turns_smp;
  logic [TURNS_W-1:0] dt;
  logic signed [AB:0] da;

  // A zero word means the encoder gave nothing; reuse the last good word.
  assign word      = (raw_word != '0) ? raw_word : held_r;
  assign raw_angle = word[RAW_W-1 -: AB];

  assign mech  = raw_angle - offset_r;
  assign d     = $signed({1'b0, mech}) - $signed({1'b0, prev_r});
  assign d_neg = -d;
  assign mag   = d[AB] ? d_neg[AB-1:0] : d[AB-1:0];
  assign mag5  = (AB+3)'({mag, 2'b00}) + (AB+3)'(mag);
  // A jump of more than 0.8 turn is taken as a wrap through zero.
  assign wrap  = mag5 > ((AB+3)'(1) << (AB+2));

  always_comb begin
    turns_smp = turns_r;
    if (wrap) begin
      turns_smp = d[AB] ? (turns_r + 32'd1) : (turns_r - 32'd1);
    end
  end

  assign dt = turns_r - tprev_turns_r;
  assign da = $signed({1'b0, prev_r}) - $signed({1'b0, tprev_angle_r});

  always_comb begin
    held_nxt        = held_r;
    offset_nxt      = offset_r;
    prev_nxt        = prev_r;
    turns_nxt       = turns_r;
    tprev_angle_nxt = tprev_angle_r;
    tprev_turns_nxt = tprev_turns_r;
    angle_nxt       = prev_r;
    tout_nxt        = turns_r;
    delta_nxt       = '0;
    unique case (action)
      ACT_SAMPLE: begin
        held_nxt  = word;
        prev_nxt  = mech;
        turns_nxt = turns_smp;
        angle_nxt = mech;
        tout_nxt  = turns_smp;
      end
      ACT_TICK: begin
        tprev_angle_nxt = prev_r;
        tprev_turns_nxt = turns_r;
        delta_nxt = DW'($signed({dt, {AB{1'b0}}})) + DW'(da);
      end
      ACT_ZERO: begin
        held_nxt   = word;
        offset_nxt = raw_angle;
        angle_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r        <= '0;
      offset_r      <= '0;
      prev_r        <= '0;
      turns_r       <= '0;
      tprev_angle_r <= '0;
      tprev_turns_r <= '0;
    end else if (en) begin
      held_r        <= held_nxt;
      offset_r      <= offset_nxt;
      prev_r        <= prev_nxt;
      turns_r       <= turns_nxt;
      tprev_angle_r <= tprev_angle_nxt;
      tprev_turns_r <= tprev_turns_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
      tout_r  <= tout_nxt;
      delta_r <= delta_nxt;
    end
  end

  assign angle_o = angle_r;
  assign turns_o = tout_r;
  assign delta_o = delta_r;

endmodule

`default_nettype wire

[sv/eatst_scale.sv]
// ---------------------------------------------------------------------------
// eatst_scale: electrical angle product and speed scaling with saturation
// Two registered stages: partial products, then combine, shift, saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module eatst_scale #(
  parameter int ANGLE_BITS = eatst_pkg::ANGLE_BITS_DEF,
  parameter int DW         = ANGLE_BITS + 33
) (
  input  wire logic                               clk,
  input  wire eatst_pkg::pipe_ctl_t               ctl,
  input  wire logic [ANGLE_BITS-1:0]              angle_i,
  input  wire logic signed [DW-1:0]               delta_i,
  input  wire logic [eatst_pkg::PP_W-1:0]         pole_pairs,
  input  wire logic [eatst_pkg::GAIN_W-1:0]       speed_gain,
  output logic [eatst_pkg::ELEC_W-1:0]            elec_o,
  output logic signed [eatst_pkg::SPEED_W-1:0]    speed_o
);
  import eatst_pkg::*;

  localparam int EW = ANGLE_BITS + PP_W;
  localparam int PW = (EW > ELEC_W) ? EW : ELEC_W;
  localparam int LW = 24;              // low slice of the delta
  localparam int HW = DW - LW + GAIN_W + 1;
  localparam int XW = DW + GAIN_W + 1;
  localparam logic signed [XW-1:0] SAT_MAX = XW'(32'sh7FFF_FFFF);
  localparam logic signed [XW-1:0] SAT_MIN = XW'(32'sh8000_0000);

  logic [PW-1:0]           elec_prod;
  logic signed [HW-1:0]    ph;
  logic [LW+GAIN_W-1:0]    pl;
  logic [ELEC_W-1:0]       elec2_r;
  logic signed [HW-1:0]    ph_r;
  logic [LW+GAIN_W-1:0]    pl_r;
  logic signed [XW-1:0]    x;
  logic signed [XW-1:0]    q;
  logic signed [SPEED_W-1:0] sat;
  logic [ELEC_W-1:0]       elec3_r;
  logic signed [SPEED_W-1:0] speed_r;

  assign elec_prod = PW'(angle_i) * PW'(pole_pairs);

  // The delta is split so that each product stays a modest width.
  assign ph = HW'($signed(delta_i[DW-1:LW])) * HW'($signed({1'b0, speed_gain}));
  assign pl = (LW+GAIN_W)'(delta_i[LW-1:0]) * (LW+GAIN_W)'(speed_gain);

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      elec2_r <= elec_prod[ELEC_W-1:0];
      ph_r    <= ph;
      pl_r    <= pl;
    end
  end

  assign x = (XW'(ph_r) <<< LW) + $signed(XW'(pl_r));
  assign q = x >>> 8;

  always_comb begin
    if (q > SAT_MAX) begin
      sat = SAT_MAX[SPEED_W-1:0];
    end else if (q < SAT_MIN) begin
      sat = SAT_MIN[SPEED_W-1:0];
    end else begin
      sat = q[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      elec3_r <= elec2_r;
      speed_r <= sat;
    end
  end

  assign elec_o  = elec3_r;
  assign speed_o = speed_r;

endmodule

`default_nettype wire

[sv/encoder_angle_turns_speed_tracker.sv]
// ---------------------------------------------------------------------------
// encoder_angle_turns_speed_tracker: multiturn encoder angle and speed
// Top level: input register, pipeline control, configuration registers.
// ---------------------------------------------------------------------------
// Usage. Each input item carries an action and a raw 16-bit encoder word.
// An angle sample returns the offset-corrected mechanical angle, the
// electrical angle and the signed turn count; a speed tick returns the
// scaled angle change since the previous tick; a zero capture stores the
// current angle as the zero offset. Every item gives exactly one result.
// Both channels are valid/ready; an item moves on a cycle where both are
// high. The configuration port is a plain write port (cfg_we, cfg_index,
// cfg_wdata); the user must write it only while the block holds no items;
// the block itself does not enforce this. A result reaches out_valid
// through the input register, the tracker stage, the multiply stage and
// the output register. The state update happens in the tracker stage, so
// one item per cycle is sustained while out_ready stays high.
// When the receiver stalls, results back up stage by stage; in_ready drops
// only once all four stages hold items. Reset clears the tracker state,
// empties the pipeline and restores pole_pairs to 7 and speed_gain to 256.
// ---------------------------------------------------------------------------
`default_nettype none

module encoder_angle_turns_speed_tracker #(
  parameter int ANGLE_BITS = eatst_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire eatst_pkg::in_item_t               in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output eatst_pkg::out_item_t                   out_data,
  input  wire logic                              cfg_we,
  input  wire logic [eatst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [eatst_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import eatst_pkg::*;

  // Width of the signed tick delta: turns times resolution plus angle step.
  localparam int DW = ANGLE_BITS + 33;
  localparam int AW = (ANGLE_BITS > MECH_W) ? ANGLE_BITS : MECH_W;

  // Stage valids: 0 input register, 1 tracker, 2 multiply, 3 output.
  logic v0_r, v1_r, v2_r, v3_r;
  logic v0_nxt, v1_nxt, v2_nxt, v3_nxt;
  logic rdy0, rdy1, rdy2, rdy3;
  logic in_fire, mv01, mv12, mv23;

  in_item_t in_r;

  logic [PP_W-1:0]   pole_pairs_r;
  logic [GAIN_W-1:0] speed_gain_r;

  logic [ANGLE_BITS-1:0]  angle1;
  logic [TURNS_W-1:0]     turns1;
  logic signed [DW-1:0]   delta1;
  logic [AW-1:0]          angle1_ext;

  logic [MECH_W-1:0]  mech2_r, mech3_r;
  logic [TURNS_W-1:0] turns2_r, turns3_r;

  logic [ELEC_W-1:0]         elec3;
  logic signed [SPEED_W-1:0] speed3;
  pipe_ctl_t                 scale_ctl;

  // Each stage can take a new item when it is empty or its item leaves.
  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  assign in_ready = rdy0;
  assign in_fire  = in_valid && rdy0;
  assign mv01     = v0_r && rdy1;
  assign mv12     = v1_r && rdy2;
  assign mv23     = v2_r && rdy3;

  always_comb begin
    v0_nxt = in_fire ? 1'b1 : (mv01 ? 1'b0 : v0_r);
    v1_nxt = mv01 ? 1'b1 : (mv12 ? 1'b0 : v1_r);
    v2_nxt = mv12 ? 1'b1 : (mv23 ? 1'b0 : v2_r);
    v3_nxt = mv23 ? 1'b1 : (out_ready ? 1'b0 : v3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
  end

  // Config registers: user writes only while the pipeline is empty, unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_pairs_r <= PP_RESET;
      speed_gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLE_PAIRS: pole_pairs_r <= cfg_wdata[PP_W-1:0];
        REG_SPEED_GAIN: speed_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The tracker stage updates the state as the item leaves the input register.
  eatst_core #(
    .ANGLE_BITS (ANGLE_BITS),
    .DW         (DW)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (mv01),
    .action   (in_r.action),
    .raw_word (in_r.raw_word),
    .angle_o  (angle1),
    .turns_o  (turns1),
    .delta_o  (delta1)
  );

  assign scale_ctl.ld_mul = mv12;
  assign scale_ctl.ld_out = mv23;

  eatst_scale #(
    .ANGLE_BITS (ANGLE_BITS),
    .DW         (DW)
  ) u_scale (
    .clk        (clk),
    .ctl        (scale_ctl),
    .angle_i    (angle1),
    .delta_i    (delta1),
    .pole_pairs (pole_pairs_r),
    .speed_gain (speed_gain_r),
    .elec_o     (elec3),
    .speed_o    (speed3)
  );

  // The reported mechanical angle keeps the low twelve bits of the angle.
  assign angle1_ext = AW'(angle1);

  always_ff @(posedge clk) begin
    if (mv12) begin
      mech2_r  <= angle1_ext[MECH_W-1:0];
      turns2_r <= turns1;
    end
    if (mv23) begin
      mech3_r  <= mech2_r;
      turns3_r <= turns2_r;
    end
  end

  assign out_valid           = v3_r;
  assign out_data.mech_angle = mech3_r;
  assign out_data.elec_angle = elec3;
  assign out_data.turn_count = $signed(turns3_r);
  assign out_data.speed      = speed3;

  // Input back-pressure only ever comes from a stalled, full pipeline.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v0_r && v1_r && v2_r && v3_r && !out_ready))
    else $error("in_ready low while the pipeline has room");

  // An item never sits behind an empty stage.
  a_stage0_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && !v1_r) |=> v1_r)
    else $error("input register item did not advance into an empty stage");

  a_stage1_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !v2_r) |=> v2_r)
    else $error("tracker stage item did not advance into an empty stage");

endmodule

`default_nettype wire
